[sv/adpcm_dec_pkg.sv]
// ----------------------------------------------------------------------------
// adpcm_dec_pkg
// shared types, constants and helpers of the block adpcm decoder
// ----------------------------------------------------------------------------
package adpcm_dec_pkg;

   localparam int CHANNELS_DEFAULT = 2;

   // tap tables: five signed 8-bit coefficients, entry i at bits 8i
   localparam int TAP_TABLE_W  = 40;
   localparam int TAP_W        = 8;
   localparam int FILTER_COUNT = 5;
   localparam logic [TAP_TABLE_W-1:0] FIRST_TAP_RESET  = 40'h7A62733C00;
   localparam logic [TAP_TABLE_W-1:0] SECOND_TAP_RESET = 40'hC4C9CC0000;

   localparam int SAMPLE_W = 16;
   localparam int SHIFT_W  = 4;
   localparam int FILTER_W = 3;
   localparam logic [SHIFT_W-1:0]  SHIFT_BASE = 4'hC;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   // csr port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   typedef enum logic {
      REG_FIRST_TAP  = 1'b0,
      REG_SECOND_TAP = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic       chan;
      logic       is_header;
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       out_chan;
      logic                       last;
   } rsp_type;

   // operands of one sample computation
   typedef struct packed {
      logic [3:0]                 nibble;
      logic [SHIFT_W-1:0]         shift;
      logic [FILTER_W-1:0]        filter;
      logic signed [SAMPLE_W-1:0] recent;
      logic signed [SAMPLE_W-1:0] older;
   } calc_in_type;

   // coefficient select, unused filter codes give zero
   function automatic logic signed [TAP_W-1:0] tap_pick(
      input logic [TAP_TABLE_W-1:0] tbl,
      input logic [FILTER_W-1:0]    sel
   );
      logic signed [TAP_W-1:0] tap;
      case (sel)
         3'd0:    tap = tbl[0*TAP_W +: TAP_W];
         3'd1:    tap = tbl[1*TAP_W +: TAP_W];
         3'd2:    tap = tbl[2*TAP_W +: TAP_W];
         3'd3:    tap = tbl[3*TAP_W +: TAP_W];
         3'd4:    tap = tbl[4*TAP_W +: TAP_W];
         default: tap = '0;
      endcase
      return tap;
   endfunction

endpackage

[sv/four_bit_adpcm_block_decoder_unit.sv]
// ----------------------------------------------------------------------------
// four_bit_adpcm_block_decoder_unit
// block-based 4-bit adpcm decoder with two-tap prediction, per-channel state
// ----------------------------------------------------------------------------
// path: a taken byte waits in the item register, and its samples pass through the result register
// throughput: header or muted bytes one per cycle; a data byte is held until both its
//    samples are in the single result register, which takes one sample per cycle when not stalled
// reset: synchronous, clears history, shift, filter and enable of every channel,
//    empties both registers and loads the default tap tables
// ----------------------------------------------------------------------------
module four_bit_adpcm_block_decoder_unit #(
   parameter int CHANNELS = adpcm_dec_pkg::CHANNELS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input byte channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  adpcm_dec_pkg::req_type                 req_data,
   // sample channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output adpcm_dec_pkg::rsp_type                 rsp_data,
   // register port
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [adpcm_dec_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [adpcm_dec_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [adpcm_dec_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready
);
   import adpcm_dec_pkg::*;

   localparam int CHAN_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // tap tables
   logic [TAP_TABLE_W-1:0] first_tap_ff,  first_tap_in;
   logic [TAP_TABLE_W-1:0] second_tap_ff, second_tap_in;

   // item register and nibble phase
   req_type item_ff,       item_in;
   logic    item_valid_ff, item_valid_in;
   logic    phase_ff,      phase_in;

   // result register
   rsp_type rsp_ff,       rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;

   // per-channel decoder state
   logic signed [SAMPLE_W-1:0] recent_ff  [CHANNELS];
   logic signed [SAMPLE_W-1:0] recent_in  [CHANNELS];
   logic signed [SAMPLE_W-1:0] older_ff   [CHANNELS];
   logic signed [SAMPLE_W-1:0] older_in   [CHANNELS];
   logic [SHIFT_W-1:0]         shift_ff   [CHANNELS];
   logic [SHIFT_W-1:0]         shift_in   [CHANNELS];
   logic [FILTER_W-1:0]        filter_ff  [CHANNELS];
   logic [FILTER_W-1:0]        filter_in  [CHANNELS];
   logic                       enabled_ff [CHANNELS];
   logic                       enabled_in [CHANNELS];

   logic [CHAN_IDX_W-1:0]      idx;
   logic                       chan_ok;
   logic                       data_live;
   logic                       rsp_free;
   logic                       emit;
   logic                       item_done;
   logic                       accept_in;
   logic                       csr_write;
   logic [3:0]                 hdr_lo;
   logic [3:0]                 hdr_hi;
   calc_in_type                calc_in;
   logic signed [SAMPLE_W-1:0] sample;

   // ---------------------------------------------------------------- csr port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // low address bits are a byte offset inside the 64-bit register slot
   always_comb begin
      first_tap_in  = first_tap_ff;
      second_tap_in = second_tap_ff;
      if (csr_write) begin
         unique case (csr_paddr[3])
            REG_FIRST_TAP:  first_tap_in  = csr_pwdata[TAP_TABLE_W-1:0];
            REG_SECOND_TAP: second_tap_in = csr_pwdata[TAP_TABLE_W-1:0];
            default:        first_tap_in  = first_tap_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3])
         REG_FIRST_TAP:  csr_prdata = CSR_DATA_W'(first_tap_ff);
         REG_SECOND_TAP: csr_prdata = CSR_DATA_W'(second_tap_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- control
   // a channel number past the configured count is dropped without a result
   assign idx     = CHAN_IDX_W'(item_ff.chan);
   assign chan_ok = (32'(item_ff.chan) < CHANNELS);

   // data byte in an enabled block produces two samples, one per cycle while the result register is free
   assign data_live = item_valid_ff && !item_ff.is_header && chan_ok && enabled_ff[idx];
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = data_live && rsp_free;

   // headers, muted and stray bytes retire without stalling the byte channel; data after its high nibble
   assign item_done = item_valid_ff && (!data_live || (emit && phase_ff));
   assign req_stall = item_valid_ff && !item_done;
   assign accept_in = req_valid && !req_stall;

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      if (accept_in) begin
         item_in       = req_data;
         item_valid_in = 1'b1;
      end else if (item_done) begin
         item_valid_in = 1'b0;
      end
   end

   // phase wraps back to the low nibble after the second sample
   assign phase_in = emit ? !phase_ff : phase_ff;

   // ---------------------------------------------------------------- datapath
   assign calc_in.nibble = phase_ff ? item_ff.in_byte[7:4] : item_ff.in_byte[3:0];
   assign calc_in.shift  = shift_ff[idx];
   assign calc_in.filter = filter_ff[idx];
   assign calc_in.recent = recent_ff[idx];
   assign calc_in.older  = older_ff[idx];

   adpcm_dec_sample u_sample (
      .calc_in     (calc_in),
      .first_taps  (first_tap_ff),
      .second_taps (second_tap_ff),
      .sample      (sample)
   );

   // result register, refilled in the same cycle its sample is transferred
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_in.sample   = sample;
         rsp_in.out_chan = item_ff.chan;
         rsp_in.last     = phase_ff;
         rsp_valid_in    = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------- channel state
   assign hdr_lo = item_ff.in_byte[3:0];
   assign hdr_hi = item_ff.in_byte[7:4];

   always_comb begin
      recent_in  = recent_ff;
      older_in   = older_ff;
      shift_in   = shift_ff;
      filter_in  = filter_ff;
      enabled_in = enabled_ff;
      // history moves along with every sample handed to the result register
      if (emit) begin
         older_in[idx]  = recent_ff[idx];
         recent_in[idx] = sample;
      end
      // header: shift clamps at zero, a filter code of five or more mutes the block
      if (item_valid_ff && item_ff.is_header && chan_ok) begin
         shift_in[idx] = (hdr_lo > SHIFT_BASE) ? '0 : SHIFT_BASE - hdr_lo;
         if (32'(hdr_hi) < FILTER_COUNT) begin
            filter_in[idx]  = hdr_hi[FILTER_W-1:0];
            enabled_in[idx] = 1'b1;
         end else begin
            enabled_in[idx] = 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_tap_ff  <= FIRST_TAP_RESET;
         second_tap_ff <= SECOND_TAP_RESET;
         item_valid_ff <= 1'b0;
         phase_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            recent_ff[c]  <= '0;
            older_ff[c]   <= '0;
            shift_ff[c]   <= '0;
            filter_ff[c]  <= '0;
            enabled_ff[c] <= 1'b0;
         end
      end else begin
         first_tap_ff  <= first_tap_in;
         second_tap_ff <= second_tap_in;
         item_valid_ff <= item_valid_in;
         phase_ff      <= phase_in;
         rsp_valid_ff  <= rsp_valid_in;
         recent_ff     <= recent_in;
         older_ff      <= older_in;
         shift_ff      <= shift_in;
         filter_ff     <= filter_in;
         enabled_ff    <= enabled_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

endmodule

[sv/adpcm_dec_sample.sv]
// ----------------------------------------------------------------------------
// adpcm_dec_sample
// one nibble to one clamped sample: scaled nibble plus two-tap prediction
// ----------------------------------------------------------------------------
module adpcm_dec_sample (
   input  adpcm_dec_pkg::calc_in_type                    calc_in,
   input  logic [adpcm_dec_pkg::TAP_TABLE_W-1:0]         first_taps,
   input  logic [adpcm_dec_pkg::TAP_TABLE_W-1:0]         second_taps,
   output logic signed [adpcm_dec_pkg::SAMPLE_W-1:0]     sample
);
   import adpcm_dec_pkg::*;

   logic signed [TAP_W-1:0] f0;
   logic signed [TAP_W-1:0] f1;
   logic signed [3:0]       nib_s;
   logic signed [17:0]      scaled;
   logic signed [23:0]      prod1;
   logic signed [23:0]      prod2;
   logic signed [24:0]      pred;
   logic signed [24:0]      pred_adj;
   logic signed [16:0]      quot;
   logic signed [17:0]      sum;

   assign f0    = tap_pick(first_taps, calc_in.filter);
   assign f1    = tap_pick(second_taps, calc_in.filter);
   assign nib_s = calc_in.nibble;

   assign scaled = 18'(nib_s) <<< calc_in.shift;

   assign prod1 = 24'(calc_in.recent) * 24'(f0);
   assign prod2 = 24'(calc_in.older) * 24'(f1);
   assign pred  = 25'(prod1) + 25'(prod2);

   // divide by 256, rounding toward zero
   assign pred_adj = pred[24] ? pred + 25'sd255 : pred;
   assign quot     = 17'(pred_adj >>> 8);

   assign sum = scaled + 18'(quot);

   always_comb begin
      if (sum > 18'(SAMPLE_MAX)) begin
         sample = SAMPLE_MAX;
      end else if (sum < 18'(SAMPLE_MIN)) begin
         sample = SAMPLE_MIN;
      end else begin
         sample = sum[SAMPLE_W-1:0];
      end
   end

endmodule

[tb/four_bit_adpcm_block_decoder_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_bit_adpcm_block_decoder_unit_tb
// self-checking bench for the block adpcm decoder: a queue-fed byte driver,
// a sample monitor against a per-channel decoder model, register writes with
// read-back between phases, and random idling and stalling on both channels
// ----------------------------------------------------------------------------
module four_bit_adpcm_block_decoder_unit_tb;
   import adpcm_dec_pkg::*;

   // cycles with no transfer on either channel before the run is abandoned
   localparam int WATCHDOG_LIMIT   = 5000;
   // headers give no sample, so let the pipe settle before touching registers
   localparam int SETTLE_CYCLES    = 8;
   localparam int RANDOM_PER_PHASE = 62;
   localparam int PHASES           = 8;

   // registers are wider than 32 bits, so they sit on 8-byte boundaries
   localparam logic [CSR_ADDR_W-1:0] ADDR_FIRST_TAP  = CSR_ADDR_W'(8 * int'(REG_FIRST_TAP));
   localparam logic [CSR_ADDR_W-1:0] ADDR_SECOND_TAP = CSR_ADDR_W'(8 * int'(REG_SECOND_TAP));

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   four_bit_adpcm_block_decoder_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // bytes waiting to be offered, and decoded samples waiting to come out
   req_type byte_queue[$];
   rsp_type pending_samples[$];

   // decoder model: tap tables and per-channel history, shift, filter, enable
   logic [TAP_TABLE_W-1:0]     first_taps  = FIRST_TAP_RESET;
   logic [TAP_TABLE_W-1:0]     second_taps = SECOND_TAP_RESET;
   logic signed [SAMPLE_W-1:0] hist_recent [CHANNELS_DEFAULT] = '{default: '0};
   logic signed [SAMPLE_W-1:0] hist_older  [CHANNELS_DEFAULT] = '{default: '0};
   logic [SHIFT_W-1:0]         chan_shift  [CHANNELS_DEFAULT] = '{default: '0};
   logic [FILTER_W-1:0]        chan_filter [CHANNELS_DEFAULT] = '{default: '0};
   logic                       chan_live   [CHANNELS_DEFAULT] = '{default: 1'b0};

   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   int   mismatch_count = 0;
   int   quiet_cycles   = 0;
   logic req_taken      = 1'b0;

   // signed coefficient of a filter from a packed table
   function automatic int tap_value(logic [TAP_TABLE_W-1:0] tbl, logic [FILTER_W-1:0] sel);
      logic signed [TAP_W-1:0] raw;
      raw = tbl[sel*TAP_W +: TAP_W];
      return int'(raw);
   endfunction

   // one nibble through the two-tap predictor, history moves along by one
   function automatic logic signed [SAMPLE_W-1:0] next_sample(int c, logic [3:0] nib);
      int delta;
      int f0;
      int f1;
      int pred;
      int v;
      delta = nib[3] ? int'(nib) - 16 : int'(nib);
      f0    = tap_value(first_taps, chan_filter[c]);
      f1    = tap_value(second_taps, chan_filter[c]);
      pred  = int'(hist_recent[c]) * f0 + int'(hist_older[c]) * f1;
      // integer division truncates toward zero, as the prediction needs
      v     = delta * (1 << chan_shift[c]) + pred / 256;
      if (v > int'(SAMPLE_MAX)) v = int'(SAMPLE_MAX);
      if (v < int'(SAMPLE_MIN)) v = int'(SAMPLE_MIN);
      hist_older[c]  = hist_recent[c];
      hist_recent[c] = SAMPLE_W'(v);
      return SAMPLE_W'(v);
   endfunction

   // effect of one accepted byte: header updates channel state, data in a live block gives two samples
   function automatic void decode_byte(req_type item);
      int               c;
      int               k;
      rsp_type          s;
      logic [3:0]       lo;
      c = int'(item.chan);
      if (item.is_header) begin
         lo = item.in_byte[3:0];
         // low nibble above twelve would underflow, shift falls back to zero
         chan_shift[c] = (lo > SHIFT_BASE) ? '0 : SHIFT_BASE - lo;
         if (item.in_byte[7:4] < FILTER_COUNT) begin
            chan_filter[c] = item.in_byte[6:4];
            chan_live[c]   = 1'b1;
         end else begin
            // unknown filter mutes the block, history left alone
            chan_live[c] = 1'b0;
         end
      end else if (chan_live[c]) begin
         for (k = 0; k < 2; k++) begin
            s.sample   = next_sample(c, item.in_byte[4*k +: 4]);
            s.out_chan = item.chan;
            s.last     = (k == 1);
            pending_samples.insert(pending_samples.size(), s);
         end
      end
   endfunction

   // driver: new byte and stall decision at the falling edge
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         // previous byte gone (or none offered): offer the next one unless idling
         if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= byte_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: sample transfers checked first, then the byte transfer is predicted
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_taken    = 1'b0;
         quiet_cycles = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_samples.size() == 0) begin
               $error("sample transfer with nothing expected: sample %0d out_chan %0d last %0d",
                      rsp_data.sample, rsp_data.out_chan, rsp_data.last);
               mismatch_count++;
            end else begin
               want = pending_samples.pop_front();
               if (rsp_data.sample !== want.sample) begin
                  $error("sample: expected %0d, got %0d", want.sample, rsp_data.sample);
                  mismatch_count++;
               end
               if (rsp_data.out_chan !== want.out_chan) begin
                  $error("out_chan: expected %0d, got %0d", want.out_chan, rsp_data.out_chan);
                  mismatch_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_data.last);
                  mismatch_count++;
               end
            end
         end
         req_taken = req_valid && !req_stall;
         if (req_taken) decode_byte(req_data);
         if (req_taken || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
      end
   end

   // watchdog on transfer activity
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   // one register access: setup cycle, then access cycle until pready
   task automatic csr_access(input logic write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic check_tap_reg(input logic [CSR_ADDR_W-1:0] addr,
                                input logic [TAP_TABLE_W-1:0] want);
      logic [CSR_DATA_W-1:0] got;
      csr_access(1'b0, addr, '0, got);
      if (got !== CSR_DATA_W'(want)) begin
         $error("tap register at %0d: expected %h, got %h", addr, want, got);
         mismatch_count++;
      end
   endtask

   // write both tables, junk in the unused upper bits, then read them back
   task automatic load_taps(input logic [TAP_TABLE_W-1:0] first,
                            input logic [TAP_TABLE_W-1:0] second);
      logic [CSR_DATA_W-1:0] unused;
      csr_access(1'b1, ADDR_FIRST_TAP, {24'($urandom()), first}, unused);
      first_taps = first;
      csr_access(1'b1, ADDR_SECOND_TAP, {24'($urandom()), second}, unused);
      second_taps = second;
      check_tap_reg(ADDR_FIRST_TAP, first_taps);
      check_tap_reg(ADDR_SECOND_TAP, second_taps);
   endtask

   task automatic push_item(input logic c, input logic hdr, input logic [7:0] b);
      req_type item;
      item.chan      = c;
      item.is_header = hdr;
      item.in_byte   = b;
      byte_queue.insert(byte_queue.size(), item);
   endtask

   // mostly whole blocks (header then data) with random content,
   // some of them with a muted header, the rest loose random bytes
   task automatic queue_random_items(input int count);
      int         n;
      int         roll;
      int         len;
      int         j;
      logic       c;
      logic [3:0] hi;
      n = 0;
      while (n < count) begin
         roll = $urandom_range(99);
         if (roll < 15) begin
            push_item(1'($urandom()), 1'($urandom()), 8'($urandom()));
            n++;
         end else begin
            c  = 1'($urandom());
            hi = (roll < 25) ? 4'($urandom_range(15, 5)) : 4'($urandom_range(4, 0));
            push_item(c, 1'b1, {hi, 4'($urandom())});
            n++;
            len = $urandom_range(12, 1);
            for (j = 0; j < len; j++) begin
               push_item(c, 1'b0, 8'($urandom()));
               n++;
            end
         end
      end
   endtask

   // the sender holds back here until every expected sample has arrived
   task automatic wait_drained();
      while (byte_queue.size() != 0 || req_valid || pending_samples.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int phase;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values of the tap tables
      check_tap_reg(ADDR_FIRST_TAP, FIRST_TAP_RESET);
      check_tap_reg(ADDR_SECOND_TAP, SECOND_TAP_RESET);

      // directed bytes, default taps, no idling
      push_item(1'b0, 1'b0, 8'h12);   // data before any header: silent
      push_item(1'b1, 1'b0, 8'hFF);
      push_item(1'b0, 1'b1, 8'h00);   // shift 12, filter 0
      push_item(1'b0, 1'b0, 8'h77);   // largest positive nibbles
      push_item(1'b0, 1'b0, 8'h88);   // most negative nibbles
      push_item(1'b0, 1'b1, 8'h1F);   // low nibble above twelve, filter 1
      push_item(1'b0, 1'b0, 8'hFF);
      push_item(1'b1, 1'b1, 8'h2D);   // other channel, filter 2, shift underflow
      push_item(1'b1, 1'b0, 8'h07);
      push_item(1'b0, 1'b1, 8'h30);   // filter 3, full shift
      push_item(1'b0, 1'b0, 8'h77);   // prediction drives it into the clamp
      push_item(1'b0, 1'b0, 8'h77);
      push_item(1'b0, 1'b1, 8'h4E);   // filter 4
      push_item(1'b0, 1'b0, 8'h80);
      push_item(1'b0, 1'b1, 8'h50);   // filter 5 mutes the block
      push_item(1'b0, 1'b0, 8'h33);
      push_item(1'b1, 1'b1, 8'hF0);   // highest filter code, muted
      push_item(1'b1, 1'b0, 8'h44);
      push_item(1'b0, 1'b1, 8'h41);   // back on, history kept through the mute
      push_item(1'b0, 1'b0, 8'h00);
      push_item(1'b0, 1'b0, 8'hF7);
      push_item(1'b1, 1'b1, 8'h0C);   // shift exactly zero
      push_item(1'b1, 1'b0, 8'h01);
      push_item(1'b1, 1'b1, 8'h38);
      push_item(1'b1, 1'b0, 8'h88);
      queue_random_items(RANDOM_PER_PHASE);
      wait_drained();

      for (phase = 1; phase < PHASES; phase++) begin
         case (phase % 4)
            1: begin
               send_idle_pct  = 84;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 84;
            end
            3: begin
               send_idle_pct  = 29;
               recv_stall_pct = 29;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         // tap settings: all -1, all -128, all +127, zero, random, then defaults again
         case (phase)
            1: load_taps(40'hFFFFFFFFFF, 40'hFFFFFFFFFF);
            2: load_taps(40'h8080808080, 40'h8080808080);
            3: load_taps(40'h7F7F7F7F7F, 40'h7F7F7F7F7F);
            4: load_taps(40'h0000000000, 40'h0000000000);
            7: load_taps(FIRST_TAP_RESET, SECOND_TAP_RESET);
            default: load_taps({8'($urandom()), 32'($urandom())},
                               {8'($urandom()), 32'($urandom())});
         endcase
         queue_random_items(RANDOM_PER_PHASE);
         wait_drained();
      end

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
